@@ design/assert_macros.svh @@
// Assertion macros shared by the normalized convolution RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ncv_pkg.sv @@
// Types and constants of the normalized 3x3 convolution.
`default_nettype none
package ncv_pkg;
    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int TAPS    = 9;
    localparam int ROW_W   = 13;
    localparam int DIM_W   = 14;
    localparam int POS_W   = 16;
    localparam int SUM_W   = 36;
    localparam int WSUM_W  = 20;
    localparam int NUM_W   = SUM_W - 1;
    localparam int DEN_W   = WSUM_W - 1;
    localparam int OUT_W   = 24;
    localparam int KROW_W  = 3 * COEF_W;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 4;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KTOP   = 3'd2;
    localparam logic [2:0] REG_KMID   = 3'd3;
    localparam logic [2:0] REG_KBOT   = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [KROW_W-1:0] KERNEL_EDGE_RESET = 48'h0400_0800_0400;
    localparam logic [KROW_W-1:0] KERNEL_MID_RESET  = 48'h0800_1000_0800;

    localparam logic [NUM_W-1:0] OUT_POS_MAX = NUM_W'(8388607);
    localparam logic [NUM_W-1:0] OUT_NEG_MAX = NUM_W'(8388608);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DIVGO,
        ST_DIV,
        ST_DONE
    } ncv_state_t;
endpackage
`default_nettype wire

@@ design/ncv_line_mem.sv @@
// Line store memory: upper and lower row samples per column, registered read.
`default_nettype none
module ncv_line_mem
    import ncv_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [2*PIX_W-1:0]    rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [2*PIX_W-1:0] wr_data
);
    logic [2*PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ design/ncv_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ncv_divider
    import ncv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  nq_reg, nq_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, nq_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            nq_next   = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            nq_next   = {nq_reg[NUM_W-2:0], ge};
            rem_next  = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = nq_reg;
endmodule
`default_nettype wire

@@ design/normalized_conv2d_3x3.sv @@
// Top level of the normalized 3x3 convolution: control, window, MAC and stream ports.
//
// Pixels enter one word at a time in raster order; a result word for pixel p
// leaves after input word p+W+1, and W+1 flush words drain the frame tail.
// One word is worked on at a time. A word that yields no result is read from
// the line store, then written back; a flush before the frame tail is taken
// and dropped. A word that yields a result goes through the line store read,
// the shared multiply-accumulate over the nine taps, the divide setup, the
// bit-serial divider, and the load of the output register. The output
// register lets the next word in while a result waits.
`default_nettype none
`include "assert_macros.svh"
module normalized_conv2d_3x3
    import ncv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  s_tdata,   // pixel_value
    input  wire logic              s_tuser,   // operation
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // filtered_value
    output logic [1:0]             m_tuser,   // saturated, zero_weight
    output logic                   m_tlast,   // frame_end
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);
    localparam int COL_W = $clog2(MAX_WIDTH);

    // configuration
    logic [12:0]       width_reg, height_reg;
    logic [KROW_W-1:0] kern_reg [3];
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 13'd4096;
            height_reg  <= 13'd4096;
            kern_reg[0] <= KERNEL_EDGE_RESET;
            kern_reg[1] <= KERNEL_MID_RESET;
            kern_reg[2] <= KERNEL_EDGE_RESET;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_WIDTH:  width_reg   <= pwdata[12:0];
                REG_HEIGHT: height_reg  <= pwdata[12:0];
                REG_KTOP:   kern_reg[0] <= pwdata[KROW_W-1:0];
                REG_KMID:   kern_reg[1] <= pwdata[KROW_W-1:0];
                REG_KBOT:   kern_reg[2] <= pwdata[KROW_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_KTOP:   prdata = DATA_W'(kern_reg[0]);
            REG_KMID:   prdata = DATA_W'(kern_reg[1]);
            REG_KBOT:   prdata = DATA_W'(kern_reg[2]);
            default:    prdata = '0;
        endcase
    end

    // clamped geometry
    logic [DIM_W-1:0] w_eff, h_eff;
    always_comb begin
        if (width_reg == '0) w_eff = DIM_W'(1);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
        else w_eff = DIM_W'(width_reg);
        if (height_reg == '0) h_eff = DIM_W'(1);
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
        else h_eff = DIM_W'(height_reg);
    end

    // control and data state
    ncv_state_t        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [PIX_W-1:0]  win_reg [6];
    logic [PIX_W-1:0]  tap_reg [TAPS];
    logic [TAPS-1:0]   mask_reg, mask_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  mac_cnt_reg, mac_cnt_next;
    logic signed [2*PIX_W:0]    prod_reg, prod_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic signed [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic              zero_reg, zero_next;
    logic              neg_reg, neg_next;
    logic [NUM_W-1:0]  q_reg, q_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    // line store
    logic               mem_rd_en, mem_wr_en;
    logic [2*PIX_W-1:0] mem_rd_data;
    logic [PIX_W-1:0]   fresh [3];

    assign fresh[0] = mem_rd_data[PIX_W-1:0];
    assign fresh[1] = mem_rd_data[2*PIX_W-1:PIX_W];
    assign fresh[2] = pix_reg;

    ncv_line_mem #(.DEPTH(MAX_WIDTH), .AW(COL_W)) u_line_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (col_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (col_reg),
        .wr_data ({pix_reg, fresh[1]})
    );

    // divider
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0] div_den;
    logic signed [SUM_W-1:0]  acc_abs;
    logic signed [WSUM_W-1:0] wsum_abs;

    assign acc_abs  = acc_reg[SUM_W-1] ? -acc_reg : acc_reg;
    assign wsum_abs = wsum_reg[WSUM_W-1] ? -wsum_reg : wsum_reg;
    assign div_num  = acc_abs[NUM_W-1:0];
    assign div_den  = wsum_abs[DEN_W-1:0];

    ncv_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // window geometry for the word being read back
    logic              row_lt_h, in_acc, ignore_flush;
    logic signed [POS_W-1:0] ox, oy, sw, sh;
    logic              emit;
    logic [KROW_W*3-1:0] coef_vec;
    logic [CNT_W-1:0]  mac_idx;
    logic signed [COEF_W-1:0] coef_cur;

    assign row_lt_h     = DIM_W'(row_reg) < h_eff;
    assign in_acc       = s_tvalid & s_tready;
    assign ignore_flush = (s_tuser == OP_FLUSH) & row_lt_h;
    assign sw           = POS_W'(w_eff);
    assign sh           = POS_W'(h_eff);
    assign emit         = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && col_reg != '0);
    assign coef_vec     = {kern_reg[2], kern_reg[1], kern_reg[0]};
    assign mac_idx      = (mac_cnt_reg < CNT_W'(TAPS)) ? mac_cnt_reg : '0;
    assign coef_cur     = coef_vec[mac_idx*COEF_W +: COEF_W];

    always_comb begin
        if (col_reg != '0) begin
            ox = POS_W'(col_reg) - POS_W'(1);
            oy = POS_W'(row_reg) - POS_W'(1);
        end else begin
            ox = sw - POS_W'(1);
            oy = POS_W'(row_reg) - POS_W'(2);
        end
    end

    always_comb begin
        logic signed [POS_W-1:0] x, y;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                x = ox + POS_W'(c) - POS_W'(1);
                y = oy + POS_W'(r) - POS_W'(1);
                mask_next[r*3+c] = (x >= 0) && (y >= 0) && (x < sw) && (y < sh);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        logic [NUM_W-1:0] qsel;
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pix_next      = pix_reg;
        last_next     = last_reg;
        mac_cnt_next  = mac_cnt_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        wsum_next     = wsum_reg;
        zero_next     = zero_reg;
        neg_next      = neg_reg;
        q_next        = q_reg;
        mem_rd_en     = 1'b0;
        mem_wr_en     = 1'b0;
        div_start     = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        qsel          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && !ignore_flush) begin
                    mem_rd_en  = 1'b1;
                    pix_next   = row_lt_h ? s_tdata : '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                mem_wr_en = 1'b1;
                last_next = (ox >= sw - POS_W'(1)) && (oy >= sh - POS_W'(1));
                if (DIM_W'(col_reg) + DIM_W'(1) >= w_eff) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
                if (emit) begin
                    if ((ox >= sw - POS_W'(1)) && (oy >= sh - POS_W'(1))) begin
                        col_next = '0;
                        row_next = '0;
                    end
                    mac_cnt_next = '0;
                    acc_next     = '0;
                    wsum_next    = '0;
                    prod_next    = '0;
                    state_next   = ST_MAC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC: begin
                // product registered, then accumulated in the next cycle
                if (mac_cnt_reg < CNT_W'(TAPS) && mask_reg[mac_idx]) begin
                    prod_next = coef_cur * $signed({1'b0, tap_reg[mac_idx]});
                    wsum_next = wsum_reg + WSUM_W'(coef_cur);
                end else begin
                    prod_next = '0;
                end
                acc_next = acc_reg + SUM_W'(prod_reg);
                if (mac_cnt_reg == CNT_W'(TAPS)) begin
                    state_next = ST_DIVGO;
                end else begin
                    mac_cnt_next = mac_cnt_reg + 1'b1;
                end
            end
            ST_DIVGO: begin
                neg_next = acc_reg[SUM_W-1] ^ wsum_reg[WSUM_W-1];
                if (wsum_reg == '0) begin
                    zero_next  = 1'b1;
                    q_next     = '0;
                    state_next = ST_DONE;
                end else begin
                    zero_next  = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    q_next     = div_quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    qsel = q_reg;
                    m_tuser_next = {1'b0, zero_reg};
                    if (zero_reg) begin
                        qsel = '0;
                    end else if (!neg_reg && q_reg > OUT_POS_MAX) begin
                        qsel = OUT_POS_MAX;
                        m_tuser_next = 2'b10;
                    end else if (neg_reg && q_reg > OUT_NEG_MAX) begin
                        qsel = OUT_NEG_MAX;
                        m_tuser_next = 2'b10;
                    end
                    m_tdata_next  = (neg_reg && !zero_reg) ? OUT_W'(-qsel) : OUT_W'(qsel);
                    m_tlast_next  = last_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            mac_cnt_reg  <= '0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
            mac_cnt_reg  <= mac_cnt_next;
            if (state_reg == ST_READ) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r]   <= win_reg[3+r];
                    win_reg[3+r] <= fresh[r];
                end
            end
        end
        if (state_reg == ST_READ) begin
            for (int r = 0; r < 3; r++) begin
                tap_reg[r*3]   <= win_reg[r];
                tap_reg[r*3+1] <= win_reg[3+r];
                tap_reg[r*3+2] <= fresh[r];
            end
            mask_reg <= mask_next;
        end
        pix_reg     <= pix_next;
        last_reg    <= last_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        wsum_reg    <= wsum_next;
        zero_reg    <= zero_next;
        neg_reg     <= neg_next;
        q_reg       <= q_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_CLK(a_div_done_in_div, aclk, aresetn, div_done |-> state_reg == ST_DIV, "divider finished outside divide state")
    `ASSERT_CLK(a_accept_reads, aclk, aresetn, (in_acc && !ignore_flush) |=> state_reg == ST_READ, "accepted word did not start a line store read")
    `ASSERT_CLK(a_mac_bound, aclk, aresetn, mac_cnt_reg <= CNT_W'(TAPS), "tap counter ran past the window")
    `ASSERT_CLK(a_done_loads_out, aclk, aresetn, (state_reg == ST_DONE && !m_tvalid_reg) |=> m_tvalid_reg, "finished result not loaded into free output register")
endmodule
`default_nettype wire
